// ----- rtl/csp_pkg.sv -----
// ----------------------------------------------------------------------------
// Color string parser package
// Parse modes, field phases, character codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int unsigned CharW  = 16;
  localparam int unsigned ColorW = 32;
  localparam int unsigned AccW   = 9;
  localparam int unsigned ChanW  = 8;

  // Character codes
  localparam logic [CharW-1:0] ChNul   = 16'h0000;
  localparam logic [CharW-1:0] ChHash  = 16'h0023;
  localparam logic [CharW-1:0] ChComma = 16'h002C;
  localparam logic [CharW-1:0] ChPlus  = 16'h002B;
  localparam logic [CharW-1:0] ChMinus = 16'h002D;
  localparam logic [CharW-1:0] ChSpace = 16'h0020;
  localparam logic [CharW-1:0] ChZero  = 16'h0030;
  localparam logic [CharW-1:0] ChNine  = 16'h0039;

  // Saturation limit and largest legal channel value
  localparam logic [AccW-1:0] AccSat  = 9'd256;
  localparam logic [AccW-1:0] ChanMax = 9'd255;

  localparam logic [2:0] HexDigits  = 3'd6;
  localparam logic [1:0] LastField  = 2'd2;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_HEX   = 2'd1,
    MODE_DEC   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_IGNORE = 2'd2
  } phase_e;

  // Hex digit decode: valid flag in bit 4, value in bits 3:0
  function automatic logic [4:0] hex_decode(input logic [CharW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b1, 4'(c - 16'h0030)};
    end else if (c >= 16'h0061 && c <= 16'h0066) begin
      r = {1'b1, 4'(c - 16'h0061 + 16'd10)};
    end else if (c >= 16'h0041 && c <= 16'h0046) begin
      r = {1'b1, 4'(c - 16'h0041 + 16'd10)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/color_string_parser_top.sv -----
// ----------------------------------------------------------------------------
// Color string parser
// Hex ("#rrggbb") or decimal ("r,g,b") color string to packed RGB word.
// ----------------------------------------------------------------------------
// One code unit is taken per transfer and every unit updates the parse state
// in the cycle it is accepted, so the block sustains one unit per clock. A
// zero unit ends the string: the color is loaded into the output register and
// appears on the master side the next cycle, and the parse state returns to
// the start of a new string. The slave side keeps accepting while the output
// register is empty or is being drained in the same cycle; it stalls only while
// a finished color waits and the master side is not ready. Nonzero units
// produce no output transfer. On a malformed or out-of-range string the output
// carries default_color with the used-default flag set in tuser.
module color_string_parser_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: default_color
  input  logic                        cfg_we_i,
  input  logic [csp_pkg::ColorW-1:0]  cfg_wdata_i,
  // Slave side
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [csp_pkg::CharW-1:0]   s_axis_tdata,   // [15:0] char_code
  // Master side
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [csp_pkg::ColorW-1:0]  m_axis_tdata,   // [31:0] color
  output logic                        m_axis_tuser    // [0] used_default
);
  import csp_pkg::*;

  logic [ColorW-1:0]           dflt_q;
  mode_e                       mode_q, mode_d;
  logic [2:0]                  cnt_q, cnt_d;
  logic [1:0]                  fidx_q, fidx_d;
  phase_e                      phase_q, phase_d;
  logic                        neg_q, neg_d;
  logic [AccW-1:0]             acc_q, acc_d;
  logic [2:0][ChanW-1:0]       chan_q, chan_d;
  logic                        err_q, err_d;
  logic                        ovalid_q, ovalid_d;
  logic [ColorW-1:0]           ocolor_q, ocolor_d;
  logic                        odflt_q, odflt_d;
  logic                        s_xfer;

  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = ocolor_q;
  assign m_axis_tuser  = odflt_q;

  // Capture the default color
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= '0;
    end else if (cfg_we_i) begin
      dflt_q <= cfg_wdata_i;
    end
  end

  // Next parse state and output word
  always_comb begin
    logic [CharW-1:0]  c;
    mode_e             mode_v;
    phase_e            ph;
    logic              done;
    logic [4:0]        hx;
    logic [1:0]        k;
    logic [11:0]       prod;
    logic              err_t;
    logic [2:0][ChanW-1:0] chan_t;

    c        = s_axis_tdata;
    mode_v   = mode_q;
    ph       = phase_q;
    done     = 1'b0;
    hx       = hex_decode(c);
    k        = cnt_q[2:1];
    prod     = 12'(acc_q) * 12'd10 + 12'(c[3:0]);
    err_t    = err_q;
    chan_t   = chan_q;

    mode_d   = mode_q;
    cnt_d    = cnt_q;
    fidx_d   = fidx_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    chan_d   = chan_q;
    err_d    = err_q;
    ocolor_d = ocolor_q;
    odflt_d  = odflt_q;
    ovalid_d = ovalid_q;

    // Drain the output register
    if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    if (s_xfer && c != ChNul) begin
      // Pick the mode on the first unit
      if (mode_q == MODE_START) begin
        if (c == ChHash) begin
          mode_d = MODE_HEX;
          done   = 1'b1;
        end else begin
          mode_v = MODE_DEC;
          mode_d = MODE_DEC;
        end
      end
      if (!done && mode_v == MODE_HEX) begin
        // Shift in one hex digit, ignore units after six
        if (cnt_q < HexDigits && !err_q) begin
          if (!hx[4]) begin
            err_d = 1'b1;
          end else begin
            chan_d[k] = {chan_q[k][3:0], hx[3:0]};
            cnt_d     = cnt_q + 3'd1;
          end
        end
      end else if (!done && !err_q) begin
        if (c == ChComma && fidx_q < LastField) begin
          // Close the field
          if (acc_q > ChanMax || (neg_q && acc_q != '0)) begin
            err_d = 1'b1;
          end
          chan_d[fidx_q] = acc_q[ChanW-1:0];
          phase_d        = PH_SKIP;
          neg_d          = 1'b0;
          acc_d          = '0;
          fidx_d         = fidx_q + 2'd1;
        end else begin
          if (ph == PH_SKIP) begin
            if (c inside {[16'd9:16'd13], ChSpace}) begin
              done = 1'b1;
            end else if (c == ChPlus || c == ChMinus) begin
              neg_d   = (c == ChMinus);
              phase_d = PH_DIGITS;
              done    = 1'b1;
            end else begin
              ph      = PH_DIGITS;
              phase_d = PH_DIGITS;
            end
          end
          if (!done && ph == PH_DIGITS) begin
            if (c >= ChZero && c <= ChNine) begin
              acc_d = (prod > 12'(AccSat)) ? AccSat : prod[AccW-1:0];
            end else begin
              phase_d = PH_IGNORE;
            end
          end
        end
      end
    end else if (s_xfer) begin
      // Terminator: finish and load the result
      if (mode_q == MODE_HEX) begin
        if (cnt_q < HexDigits) begin
          err_t = 1'b1;
        end
      end else if (fidx_q < LastField) begin
        err_t = 1'b1;
      end else if (!err_q) begin
        if (acc_q > ChanMax || (neg_q && acc_q != '0)) begin
          err_t = 1'b1;
        end
        chan_t[LastField] = acc_q[ChanW-1:0];
      end
      ovalid_d = 1'b1;
      odflt_d  = err_t;
      ocolor_d = err_t ? dflt_q : {8'h00, chan_t[2], chan_t[1], chan_t[0]};
      mode_d   = MODE_START;
      cnt_d    = '0;
      fidx_d   = '0;
      phase_d  = PH_SKIP;
      neg_d    = 1'b0;
      acc_d    = '0;
      chan_d   = '0;
      err_d    = 1'b0;
    end
  end

  // Parse state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_START;
      cnt_q    <= '0;
      fidx_q   <= '0;
      phase_q  <= PH_SKIP;
      neg_q    <= 1'b0;
      acc_q    <= '0;
      chan_q   <= '0;
      err_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      fidx_q   <= fidx_d;
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      acc_q    <= acc_d;
      chan_q   <= chan_d;
      err_q    <= err_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    ocolor_q <= ocolor_d;
    odflt_q  <= odflt_d;
  end

`ifndef SYNTH
  a_no_result_on_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && s_axis_tdata != ChNul |=> !m_axis_tvalid)
    else $error("output transfer raised by a nonzero unit");

  a_result_and_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && s_axis_tdata == ChNul |=>
      m_axis_tvalid && mode_q == MODE_START && acc_q == '0 && !err_q)
    else $error("terminator did not load result or clear parse state");

  a_hex_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= HexDigits)
    else $error("hex digit count past six");

  a_acc_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= AccSat)
    else $error("accumulator above saturation limit");

  a_rgb_top_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:24] == 8'h00)
    else $error("parsed color has nonzero top byte");
`endif

endmodule

// ----- verif/tb_color_string_parser_top.sv -----
// ----------------------------------------------------------------------------
// Color string parser testbench
// Streams hex and decimal color strings into the parser under random idling
// on both sides and checks every output color against a cycle-free predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_color_string_parser_top;
  import csp_pkg::*;

  localparam time         ClkPeriod     = 12ns;
  localparam int unsigned ItemsPerPhase = 370;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned SettleCycles  = 8;

  // Character codes not provided by the package
  localparam logic [CharW-1:0] WsLow = 16'h0009;
  localparam logic [CharW-1:0] WsHigh = 16'h000D;
  localparam logic [CharW-1:0] LowA = 16'h0061;
  localparam logic [CharW-1:0] LowF = 16'h0066;
  localparam logic [CharW-1:0] UpA = 16'h0041;
  localparam logic [CharW-1:0] UpF = 16'h0046;

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic              used_default;
  } color_result_t;

  // Predicts the color word for each string and holds the pending ones
  class color_predictor;
    logic [ColorW-1:0] default_color;
    mode_e             mode;
    logic [2:0]        hex_count;
    logic [1:0]        field_idx;
    phase_e            phase;
    logic              negative;
    logic [AccW-1:0]   magnitude;
    logic [ChanW-1:0]  channel [3];
    logic              failed;
    color_result_t     expected_colors [$];
    int                errors;

    function new();
      default_color = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      mode = MODE_START;
      hex_count = '0;
      field_idx = '0;
      phase = PH_SKIP;
      negative = 1'b0;
      magnitude = '0;
      channel[0] = '0;
      channel[1] = '0;
      channel[2] = '0;
      failed = 1'b0;
    endfunction

    // Store the field value and flag it when out of range
    function void close_field();
      if (magnitude > ChanMax || (negative && magnitude != '0)) failed = 1'b1;
      channel[field_idx] = magnitude[ChanW-1:0];
      phase = PH_SKIP;
      negative = 1'b0;
      magnitude = '0;
    endfunction

    function void take_char(logic [CharW-1:0] c);
      int nibble;
      int value;
      if (c != ChNul) begin
        if (mode == MODE_START) begin
          if (c == ChHash) begin
            mode = MODE_HEX;
            return;
          end
          mode = MODE_DEC;
        end
        if (mode == MODE_HEX) begin
          if (hex_count < HexDigits && !failed) begin
            nibble = -1;
            if (c >= ChZero && c <= ChNine) nibble = int'(c - ChZero);
            else if (c >= LowA && c <= LowF) nibble = int'(c - LowA) + 10;
            else if (c >= UpA && c <= UpF) nibble = int'(c - UpA) + 10;
            if (nibble < 0) begin
              failed = 1'b1;
            end else begin
              channel[hex_count >> 1] = {channel[hex_count >> 1][3:0], nibble[3:0]};
              hex_count++;
            end
          end
        end else if (!failed) begin
          // The first two commas split the fields
          if (c == ChComma && field_idx < LastField) begin
            close_field();
            field_idx++;
            return;
          end
          if (phase == PH_SKIP) begin
            if (c == ChSpace || (c >= WsLow && c <= WsHigh)) return;
            if (c == ChPlus || c == ChMinus) begin
              negative = (c == ChMinus);
              phase = PH_DIGITS;
              return;
            end
            phase = PH_DIGITS;
          end
          if (phase == PH_DIGITS) begin
            if (c >= ChZero && c <= ChNine) begin
              value = magnitude * 10 + int'(c - ChZero);
              magnitude = (value > AccSat) ? AccSat : value[AccW-1:0];
            end else begin
              phase = PH_IGNORE;
            end
          end
        end
        return;
      end
      // Terminator: settle the verdict and queue the color
      if (mode == MODE_HEX) begin
        if (hex_count < HexDigits) failed = 1'b1;
      end else if (field_idx < LastField) begin
        failed = 1'b1;
      end else if (!failed) begin
        close_field();
      end
      if (failed) expected_colors.push_back('{default_color, 1'b1});
      else expected_colors.push_back('{{8'h00, channel[2], channel[1], channel[0]}, 1'b0});
      restart();
    endfunction

    function void check_color(logic [ColorW-1:0] color, logic used_default);
      color_result_t want;
      if (expected_colors.size() == 0) begin
        $error("unexpected color transfer: color %h used_default %b", color, used_default);
        errors++;
        return;
      end
      want = expected_colors.pop_front();
      if (want.color !== color) begin
        $error("color: expected %h, actual %h", want.color, color);
        errors++;
      end
      if (want.used_default !== used_default) begin
        $error("used_default: expected %b, actual %b", want.used_default, used_default);
        errors++;
      end
    endfunction

    function int waiting();
      return expected_colors.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [ColorW-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [CharW-1:0]  s_axis_tdata = '0;   // [15:0] char_code
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [ColorW-1:0] m_axis_tdata;        // [31:0] color
  logic              m_axis_tuser;        // [0] used_default

  color_predictor   model = new();
  logic [CharW-1:0] str_units [$];
  int unsigned      src_idle_pct = 19;
  int unsigned      sink_idle_pct = 62;
  int unsigned      units_sent = 0;
  int unsigned      stall_count = 0;
  bit               hold_go = 1'b0;

  color_string_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Receiver: random ready, with one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HoldCycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Observe transfers on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) model.take_char(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) model.check_color(m_axis_tdata, m_axis_tuser);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offer one code unit and hold it until the transfer
  task automatic send_unit(input logic [CharW-1:0] unit);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= unit;
    do @(posedge clk_i); while (!s_axis_tready);
    units_sent++;
  endtask

  // Drain, then write the default color while the block is idle
  task automatic write_default(input logic [ColorW-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (model.waiting() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    model.default_color = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CharW-1:0] pick_hex_digit();
    int v;
    v = $urandom_range(15);
    if (v < 10) return ChZero + CharW'(v);
    return ($urandom_range(1) ? LowA : UpA) + CharW'(v - 10);
  endfunction

  // Build one terminated string: mostly well formed, some broken, some noise
  task automatic build_string();
    int kind;
    int n;
    int val;
    int roll;
    int digits [$];
    str_units.delete();
    kind = $urandom_range(99);
    if (kind < 40) begin
      str_units.push_back(ChHash);
      n = ($urandom_range(99) < 10) ? $urandom_range(0, 5) : 6;
      for (int i = 0; i < n; i++) str_units.push_back(pick_hex_digit());
      if (n > 0 && $urandom_range(99) < 8)
        str_units[$urandom_range(1, n)] = CharW'($urandom_range(1, 16'hFFFF));
      if ($urandom_range(99) < 30) begin
        repeat ($urandom_range(1, 3))
          str_units.push_back(CharW'($urandom_range(1, 16'hFFFF)));
      end
    end else if (kind < 90) begin
      for (int f = 0; f < 3; f++) begin
        if ($urandom_range(99) < 30) begin
          repeat ($urandom_range(1, 2))
            str_units.push_back($urandom_range(1) ? ChSpace :
                                CharW'($urandom_range(WsLow, WsHigh)));
        end
        roll = $urandom_range(99);
        if (roll < 8) str_units.push_back(ChPlus);
        else if (roll < 15) str_units.push_back(ChMinus);
        roll = $urandom_range(99);
        if (roll >= 12) begin
          if (roll < 80) val = $urandom_range(0, 255);
          else if (roll < 95) val = $urandom_range(256, 999);
          else val = $urandom_range(1000, 99999);
          if ($urandom_range(99) < 10) str_units.push_back(ChZero);
          digits.delete();
          do begin
            digits.push_front(val % 10);
            val = val / 10;
          end while (val > 0);
          foreach (digits[i]) str_units.push_back(ChZero + CharW'(digits[i]));
        end
        if ($urandom_range(99) < 12)
          str_units.push_back(CharW'($urandom_range(1, 16'hFFFF)));
        if (f < 2 && $urandom_range(99) < 96) str_units.push_back(ChComma);
      end
      // Stray comma inside the last field
      if ($urandom_range(99) < 5) begin
        str_units.push_back(ChComma);
        str_units.push_back(ChZero + CharW'($urandom_range(9)));
      end
    end else begin
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++)
        str_units.push_back(CharW'($urandom_range(1, 16'hFFFF)));
      if (n > 0 && $urandom_range(99) < 30) str_units[0] = ChHash;
    end
    str_units.push_back(ChNul);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = units_sent + count;
    while (units_sent < stop_at) begin
      build_string();
      foreach (str_units[i]) send_unit(str_units[i]);
    end
  endtask

  // Empty string, hex with trailing wide unit, bad hex, decimal corner cases,
  // missing commas
  localparam logic [CharW-1:0] DirectedUnits [25] = '{
    ChNul,
    ChHash, LowA, ChZero, UpF, ChNine, 16'h0062, 16'h0063, 16'hFFFF, ChNul,
    ChHash, 16'h0047, ChNul,
    WsLow, ChMinus, ChZero, ChComma, ChPlus, 16'h0032, ChComma, ChComma, ChNine, ChNul,
    ChNine, ChNul
  };

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_default($urandom());
    foreach (DirectedUnits[i]) send_unit(DirectedUnits[i]);

    // Phase 1: sender mostly busy, receiver often stalled
    run_random(ItemsPerPhase);

    // Phase 2: swapped idling
    write_default('1);
    src_idle_pct = 62;
    sink_idle_pct = 19;
    run_random(ItemsPerPhase);

    // Phase 3: no idling, one long receiver hold-off to back up the input
    write_default('0);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_go = 1'b1;
    run_random(ItemsPerPhase);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (model.waiting() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (model.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/csp_pkg.sv
rtl/color_string_parser_top.sv
verif/tb_color_string_parser_top.sv
